// ===== src/rrss_pkg.sv =====
// rrss_pkg: types, op codes and constants of the round-robin slice scheduler.
// Used by rrss_cell, rrss_ring and round_robin_slice_scheduler. No dependencies.
package rrss_pkg;

  localparam int unsigned TIME_W        = 16;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned MAX_TASKS_DEF = 64;
  localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd10;
  localparam logic [TIME_W-1:0] ROUND_FIRST   = 16'd1;
  localparam logic [TIME_W-1:0] ROUND_MAX     = 16'hFFFF;

  // Op codes of an input beat
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ISSUE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] burst_length;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  task_index;
    logic [TIME_W-1:0] slice_length;
    logic [TIME_W-1:0] round_number;
    logic              all_done;
    logic              table_full;
  } out_t;

  // Control of the cell ring: rotate by one, or write the head cell
  typedef struct packed {
    logic              shift;
    logic              wr;
    logic [TIME_W-1:0] wdata;
  } ring_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_SEEK,
    ST_ISSUE_SEEK,
    ST_SCAN,
    ST_RESULT
  } state_t;

endpackage

// ===== src/rrss_cell.sv =====
// rrss_cell: one cell of the remaining-time ring; holds one slot's time left.
// Depends on rrss_pkg for the time width.
module rrss_cell (
  input  logic                        clk,
  input  logic                        shift,
  input  logic                        wr,
  input  logic [rrss_pkg::TIME_W-1:0] shift_in,
  input  logic [rrss_pkg::TIME_W-1:0] wdata,
  output logic [rrss_pkg::TIME_W-1:0] value
);

  logic [rrss_pkg::TIME_W-1:0] value_r;
  logic [rrss_pkg::TIME_W-1:0] value_nxt;

  // take the neighbor's value on a rotate, else a local write
  always_comb begin
    value_nxt = value_r;
    if (shift) begin
      value_nxt = shift_in;
    end else if (wr) begin
      value_nxt = wdata;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ===== src/rrss_ring.sv =====
// rrss_ring: a closed row of rrss_cell; cell 0 is the head, seen by the control.
// Depends on rrss_pkg (ring_ctl_t) and rrss_cell.
module rrss_ring #(
  parameter int unsigned MAX_TASKS = rrss_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk,
  input  rrss_pkg::ring_ctl_t         ctl,
  output logic [rrss_pkg::TIME_W-1:0] head_value
);

  logic [rrss_pkg::TIME_W-1:0] cell_val [MAX_TASKS];

  // each cell takes its upper neighbor's value on a rotate; the last takes the head
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    localparam int unsigned NEXT = (i + 1) % MAX_TASKS;
    rrss_cell u_cell (
      .clk      (clk),
      .shift    (ctl.shift),
      .wr       (ctl.wr && (i == 0)),
      .shift_in (cell_val[NEXT]),
      .wdata    (ctl.wdata),
      .value    (cell_val[i])
    );
  end

  assign head_value = cell_val[0];

endmodule

// ===== src/round_robin_slice_scheduler.sv =====
// round_robin_slice_scheduler: top level, control sequencer and output register.
// Depends on rrss_pkg and rrss_ring (which uses rrss_cell).
//
// Usage:
//   Input beats (in_valid/in_stall, in_data) carry an op and a burst length.
//   A load puts the burst into the next free slot; an issue grants the next
//   task in slot order with time left a slice of min(remaining, quantum); a
//   clear empties the table. A load into a full table and an issue with no
//   time left return a flag beat (table_full or all_done).
//   Result beats leave on out_valid/out_stall from an output register; a new
//   input beat is taken while a result still waits there.
//   The per-slot times live in a rotating ring of cells; only the head cell is
//   read or written, so the ring turns until the wanted slot sits at the head.
//   A load turns the ring until the first free slot is at the head, then
//   writes it; an issue turns the ring to the serve pointer, then searches
//   onward past finished and unused slots, writes the granted slot and hands
//   the result over; the input side stalls until the sequencer is idle again.
//   Clear and unused ops need no ring turn. The user must write the quantum
//   (cfg_wr_en/cfg_wr_data) only while idle; the block itself does not enforce it.
//   Reset (rst_n low, synchronous): no tasks, serve pointer 0, round 1,
//   quantum 10, output empty. The ring contents are not cleared.
//   A stalled result holds the output register; once a second result is
//   ready the input side stalls until the first one is taken.
module round_robin_slice_scheduler #(
  parameter int unsigned MAX_TASKS = rrss_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rrss_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rrss_pkg::out_t              out_data,
  input  logic                        cfg_wr_en,
  input  logic [rrss_pkg::TIME_W-1:0] cfg_wr_data
);

  localparam int unsigned SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_TASKS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_TASKS);

  localparam int unsigned TW = rrss_pkg::TIME_W;

  rrss_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]    tc_r, tc_nxt;
  logic [SLOT_W-1:0]   sp_r, sp_nxt;
  logic [TW-1:0]       round_r, round_nxt;
  logic [TW-1:0]       quantum_r, quantum_nxt;
  logic [SLOT_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]    checked_r, checked_nxt;
  logic                wrapped_r, wrapped_nxt;
  logic [TW-1:0]       burst_r, burst_nxt;
  rrss_pkg::out_t      res_r, res_nxt;
  rrss_pkg::out_t      out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  rrss_pkg::ring_ctl_t ring_ctl;
  logic [TW-1:0]       head_value;

  logic                in_fire;
  logic                out_free;
  logic [CNT_W-1:0]    head_cnt;
  logic [SLOT_W-1:0]   head_inc;
  logic [CNT_W-1:0]    slot_next;
  logic [TW-1:0]       slice;
  logic [TW-1:0]       round_a;
  logic [SLOT_W+5:0]   idx_ext;

  function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v, input logic en);
    sat_inc = (en && (v != rrss_pkg::ROUND_MAX)) ? v + TW'(1) : v;
  endfunction

  rrss_ring #(
    .MAX_TASKS (MAX_TASKS)
  ) u_ring (
    .clk        (clk),
    .ctl        (ring_ctl),
    .head_value (head_value)
  );

  assign in_stall  = (state_r != rrss_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // slot arithmetic around the head cell
  assign head_cnt  = CNT_W'(head_r);
  assign head_inc  = (head_r == SLOT_LAST) ? '0 : head_r + SLOT_W'(1);
  assign slot_next = head_cnt + CNT_W'(1);
  assign slice     = (head_value < quantum_r) ? head_value : quantum_r;
  assign round_a   = sat_inc(round_r, wrapped_r);
  assign idx_ext   = {6'b0, head_r};

  // quantum register
  always_comb begin
    quantum_nxt = quantum_r;
    if (cfg_wr_en) begin
      quantum_nxt = cfg_wr_data;
    end
  end

  // sequencer: next state, ring control and scheduler state updates
  always_comb begin
    state_nxt     = state_r;
    tc_nxt        = tc_r;
    sp_nxt        = sp_r;
    round_nxt     = round_r;
    head_nxt      = head_r;
    checked_nxt   = checked_r;
    wrapped_nxt   = wrapped_r;
    burst_nxt     = burst_r;
    res_nxt       = res_r;
    ring_ctl      = '0;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      rrss_pkg::ST_IDLE: begin
        if (in_fire) begin
          burst_nxt = in_data.burst_length;
          res_nxt   = '0;
          unique case (in_data.op)
            rrss_pkg::OP_LOAD: begin
              if (tc_r >= CNT_MAX) begin
                res_nxt.table_full = 1'b1;
                state_nxt          = rrss_pkg::ST_RESULT;
              end else begin
                state_nxt = rrss_pkg::ST_LOAD_SEEK;
              end
            end
            rrss_pkg::OP_ISSUE: begin
              if (tc_r == '0) begin
                res_nxt.all_done = 1'b1;
                state_nxt        = rrss_pkg::ST_RESULT;
              end else begin
                checked_nxt = '0;
                wrapped_nxt = 1'b0;
                state_nxt   = rrss_pkg::ST_ISSUE_SEEK;
              end
            end
            rrss_pkg::OP_CLEAR: begin
              tc_nxt    = '0;
              sp_nxt    = '0;
              round_nxt = rrss_pkg::ROUND_FIRST;
            end
            default: begin
            end
          endcase
        end
      end

      // turn the ring until the first free slot is at the head, then write it
      rrss_pkg::ST_LOAD_SEEK: begin
        if (head_cnt == tc_r) begin
          ring_ctl.wr    = 1'b1;
          ring_ctl.wdata = burst_r;
          tc_nxt         = tc_r + CNT_W'(1);
          state_nxt      = rrss_pkg::ST_IDLE;
        end else begin
          ring_ctl.shift = 1'b1;
          head_nxt       = head_inc;
        end
      end

      // turn the ring to the serve pointer
      rrss_pkg::ST_ISSUE_SEEK: begin
        if (head_r == sp_r) begin
          state_nxt = rrss_pkg::ST_SCAN;
        end else begin
          ring_ctl.shift = 1'b1;
          head_nxt       = head_inc;
        end
      end

      // look at one cell per cycle for time left, skipping unused slots
      rrss_pkg::ST_SCAN: begin
        if (head_cnt < tc_r) begin
          if (checked_r == tc_r) begin
            res_nxt          = '0;
            res_nxt.all_done = 1'b1;
            state_nxt        = rrss_pkg::ST_RESULT;
          end else if (head_value != '0) begin
            ring_ctl.wr          = 1'b1;
            ring_ctl.wdata       = head_value - slice;
            res_nxt              = '0;
            res_nxt.task_index   = idx_ext[5:0];
            res_nxt.slice_length = slice;
            res_nxt.round_number = round_a;
            if (slot_next >= tc_r) begin
              sp_nxt    = '0;
              round_nxt = sat_inc(round_a, 1'b1);
            end else begin
              sp_nxt    = slot_next[SLOT_W-1:0];
              round_nxt = round_a;
            end
            state_nxt = rrss_pkg::ST_RESULT;
          end else begin
            checked_nxt    = checked_r + CNT_W'(1);
            ring_ctl.shift = 1'b1;
            head_nxt       = head_inc;
            if (head_r == SLOT_LAST) begin
              wrapped_nxt = 1'b1;
            end
          end
        end else begin
          ring_ctl.shift = 1'b1;
          head_nxt       = head_inc;
          if (head_r == SLOT_LAST) begin
            wrapped_nxt = 1'b1;
          end
        end
      end

      // hand the result beat to the output register once it is free
      rrss_pkg::ST_RESULT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = rrss_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rrss_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrss_pkg::ST_IDLE;
      tc_r        <= '0;
      sp_r        <= '0;
      round_r     <= rrss_pkg::ROUND_FIRST;
      quantum_r   <= rrss_pkg::QUANTUM_RESET;
      head_r      <= '0;
      checked_r   <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tc_r        <= tc_nxt;
      sp_r        <= sp_nxt;
      round_r     <= round_nxt;
      quantum_r   <= quantum_nxt;
      head_r      <= head_nxt;
      checked_r   <= checked_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    burst_r <= burst_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  // checks
  a_tc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tc_r <= CNT_MAX)
    else $error("task count above table size");

  a_sp_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (sp_r == '0) || (CNT_W'(sp_r) < tc_r))
    else $error("serve pointer outside loaded slots");

  a_checked_bound: assert property (@(posedge clk) disable iff (!rst_n)
    checked_r <= tc_r || state_r != rrss_pkg::ST_SCAN)
    else $error("search passed more slots than loaded");

  a_ring_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_ctl.shift && ring_ctl.wr))
    else $error("ring rotate and head write at once");

  a_result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrss_pkg::ST_RESULT && out_free) |=> (out_valid_r && out_r == $past(res_r)))
    else $error("result beat not moved to output register");

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for round_robin_slice_scheduler (slot loads, slice grants,
// round counting and the quantum register), with its own scheduling predictor.
// Depends on rrss_pkg and the scheduler RTL; needs no files or arguments.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned TIME_W        = rrss_pkg::TIME_W;
  localparam int unsigned IDX_W         = rrss_pkg::IDX_W;
  localparam int unsigned MAX_TASKS     = rrss_pkg::MAX_TASKS_DEF;
  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned SETTLE_CYCLES = 4 * MAX_TASKS;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned ISSUE_CAP     = 300;
  localparam int unsigned PHASE_BEATS   = 165;
  localparam int unsigned N_PHASES      = 10;
  localparam int unsigned ZERO_Q_ISSUES = 20;
  localparam int unsigned IDLE_PCT      = 52;
  localparam int unsigned BOTH_PCT      = 20;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  // quantum of each random phase; extremes first, zero comes in a short run at the end
  localparam logic [TIME_W-1:0] PHASE_QUANTUM [N_PHASES] =
    '{16'd1, 16'hFFFF, 16'd10, 16'd3, 16'd2, 16'hFFFF, 16'd7, 16'd1000, 16'd1, 16'd16};

  typedef enum logic [1:0] {CHK_MODEL, CHK_GIVEN, CHK_NONE} chk_t;

  typedef struct {
    logic [1:0]        op;
    logic [TIME_W-1:0] burst;
    int unsigned       reps;
    chk_t              chk;
    rrss_pkg::out_t    want;
  } plan_row_t;

  localparam rrss_pkg::out_t NO_BEAT   = '0;
  localparam rrss_pkg::out_t DONE_BEAT = '{all_done: 1'b1, default: '0};
  localparam rrss_pkg::out_t FULL_BEAT = '{table_full: 1'b1, default: '0};

  // Directed plan, quantum at its reset value of 10
  localparam int unsigned N_ROWS = 20;
  plan_row_t plan [N_ROWS] = '{
    '{rrss_pkg::OP_ISSUE, 16'd0,    1,  CHK_GIVEN, DONE_BEAT},  // issue with an empty table
    '{OP_UNUSED,          16'hFFFF, 1,  CHK_NONE,  NO_BEAT},    // unused op is dropped
    '{rrss_pkg::OP_LOAD,  16'd15,   1,  CHK_NONE,  NO_BEAT},
    '{rrss_pkg::OP_LOAD,  16'd3,    1,  CHK_NONE,  NO_BEAT},
    '{rrss_pkg::OP_LOAD,  16'd0,    1,  CHK_NONE,  NO_BEAT},    // zero burst, done from start
    '{rrss_pkg::OP_ISSUE, 16'd0,    1,  CHK_GIVEN, '{6'd0, 16'd10, 16'd1, 1'b0, 1'b0}},
    '{rrss_pkg::OP_ISSUE, 16'd0,    1,  CHK_GIVEN, '{6'd1, 16'd3, 16'd1, 1'b0, 1'b0}},
    '{rrss_pkg::OP_ISSUE, 16'd0,    1,  CHK_MODEL, NO_BEAT},    // search wraps past the end
    '{rrss_pkg::OP_ISSUE, 16'd0,    1,  CHK_GIVEN, DONE_BEAT},
    '{rrss_pkg::OP_CLEAR, 16'd0,    1,  CHK_NONE,  NO_BEAT},
    '{rrss_pkg::OP_LOAD,  16'hFFFF, 1,  CHK_NONE,  NO_BEAT},
    '{rrss_pkg::OP_ISSUE, 16'd0,    1,  CHK_GIVEN, '{6'd0, 16'd10, 16'd1, 1'b0, 1'b0}},
    '{rrss_pkg::OP_ISSUE, 16'd0,    1,  CHK_MODEL, NO_BEAT},    // last slot served, new round
    '{rrss_pkg::OP_CLEAR, 16'd0,    1,  CHK_NONE,  NO_BEAT},
    '{rrss_pkg::OP_LOAD,  16'd1,    64, CHK_NONE,  NO_BEAT},    // fill every slot
    '{rrss_pkg::OP_LOAD,  16'h5A5A, 1,  CHK_GIVEN, FULL_BEAT},
    '{rrss_pkg::OP_ISSUE, 16'd0,    1,  CHK_MODEL, NO_BEAT},
    '{rrss_pkg::OP_ISSUE, 16'd0,    1,  CHK_MODEL, NO_BEAT},
    '{rrss_pkg::OP_CLEAR, 16'd0,    1,  CHK_NONE,  NO_BEAT},
    '{rrss_pkg::OP_ISSUE, 16'd0,    1,  CHK_GIVEN, DONE_BEAT}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  rrss_pkg::in_t     in_data;
  logic              out_valid;
  logic              out_stall;
  rrss_pkg::out_t    out_data;
  logic              cfg_wr_en;
  logic [TIME_W-1:0] cfg_wr_data;

  // Predictor state
  logic [TIME_W-1:0] slot_time [MAX_TASKS];
  int unsigned       loaded_cnt;
  int unsigned       next_slot;
  logic [TIME_W-1:0] round_no;
  logic [TIME_W-1:0] quantum_q;
  bit                table_drained;

  rrss_pkg::out_t    pending_grants [$];
  rrss_pkg::out_t    head_grant;
  int unsigned       mismatch_cnt = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;
  bit                hold_off_req = 1'b0;

  always #CLK_HALF clk = ~clk;

  round_robin_slice_scheduler u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // ---------------------------------------------------------------- predictor

  // first slot in [from, upto) with time left, MAX_TASKS if none
  function automatic int unsigned first_live(input int unsigned from, input int unsigned upto);
    for (int unsigned k = from; k < upto && k < MAX_TASKS; k++)
      if (slot_time[k] != '0) return k;
    return MAX_TASKS;
  endfunction

  task automatic advance_round();
    if (round_no != rrss_pkg::ROUND_MAX) round_no = round_no + 1'b1;
  endtask

  task automatic schedule_step(input rrss_pkg::in_t b, output bit emits,
                               output rrss_pkg::out_t r);
    int unsigned       hit;
    logic [TIME_W-1:0] grant;
    r = '0;
    emits = 1'b0;
    case (b.op)
      rrss_pkg::OP_LOAD: begin
        if (loaded_cnt >= MAX_TASKS) begin
          emits = 1'b1;
          r.table_full = 1'b1;
        end else begin
          slot_time[loaded_cnt] = b.burst_length;
          loaded_cnt++;
        end
      end
      rrss_pkg::OP_CLEAR: begin
        loaded_cnt = 0;
        next_slot  = 0;
        round_no   = rrss_pkg::ROUND_FIRST;
      end
      rrss_pkg::OP_ISSUE: begin
        emits = 1'b1;
        if (next_slot >= loaded_cnt) next_slot = 0;
        hit = first_live(next_slot, loaded_cnt);
        // nothing left up to the end: wrap to slot 0, which starts a new round
        if (hit == MAX_TASKS && next_slot != 0) begin
          hit = first_live(0, next_slot);
          if (hit != MAX_TASKS) advance_round();
        end
        table_drained = (hit == MAX_TASKS);
        if (table_drained) begin
          r.all_done = 1'b1;
        end else begin
          grant = (slot_time[hit] < quantum_q) ? slot_time[hit] : quantum_q;
          slot_time[hit]  = slot_time[hit] - grant;
          r.task_index    = hit[IDX_W-1:0];
          r.slice_length  = grant;
          r.round_number  = round_no;
          next_slot = hit + 1;
          if (next_slot >= loaded_cnt) begin
            next_slot = 0;
            advance_round();
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- input side

  function automatic rrss_pkg::in_t beat(input logic [1:0] op,
                                         input logic [TIME_W-1:0] burst);
    rrss_pkg::in_t b;
    b.op = op;
    b.burst_length = burst;
    return b;
  endfunction

  // bursts mostly a few quanta long so tasks finish; some zero, some full range
  function automatic logic [TIME_W-1:0] pick_burst();
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(19);
    span = (quantum_q == '0) ? 40 : 4 * int'(quantum_q);
    if (span > 65535) span = 65535;
    if (roll == 0) return '0;
    if (roll == 1) return 16'($urandom_range(16'hFFFF));
    return 16'($urandom_range(span, 1));
  endfunction

  // offer one beat, wait for it to be taken, then record what it should produce
  task automatic send_beat(input rrss_pkg::in_t b, input chk_t chk, input rrss_pkg::out_t want);
    bit             emits;
    rrss_pkg::out_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    schedule_step(b, emits, r);
    if (chk == CHK_MODEL && emits) pending_grants.push_back(r);
    else if (chk == CHK_GIVEN) pending_grants.push_back(want);
  endtask

  task automatic send_issue();
    send_beat(beat(rrss_pkg::OP_ISSUE, '0), CHK_MODEL, NO_BEAT);
  endtask

  // stop offering until every result is back and the block has settled
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [TIME_W-1:0] q);
    quiesce();
    cfg_wr_data <= q;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    quantum_q = q;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;        stall_pct = 0;        end
      1: begin send_idle_pct = IDLE_PCT; stall_pct = 0;        end
      2: begin send_idle_pct = 0;        stall_pct = IDLE_PCT; end
      default: begin send_idle_pct = BOTH_PCT; stall_pct = BOTH_PCT; end
    endcase
  endtask

  // Sessions: optional clear, a batch of loads, issues until all time is granted, the issue
  // cap is hit or the beat budget runs out; a few stray beats of any op in between
  task automatic random_traffic(input int unsigned n_beats);
    int unsigned   sent;
    int unsigned   n_tasks;
    int unsigned   n_issues;
    rrss_pkg::in_t b;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(99) < 8) begin
        b.op           = 2'($urandom_range(3));
        b.burst_length = 16'($urandom_range(16'hFFFF));
        send_beat(b, CHK_MODEL, NO_BEAT);
        if (b.op != OP_UNUSED) sent++;
      end else begin
        if ($urandom_range(1) == 0) begin
          send_beat(beat(rrss_pkg::OP_CLEAR, '0), CHK_MODEL, NO_BEAT);
          sent++;
        end
        // now and then run the table up to and past full
        n_tasks = ($urandom_range(9) == 0) ? $urandom_range(MAX_TASKS + 3, MAX_TASKS - 4)
                                           : $urandom_range(6, 1);
        repeat (n_tasks) begin
          send_beat(beat(rrss_pkg::OP_LOAD, pick_burst()), CHK_MODEL, NO_BEAT);
          sent++;
        end
        n_issues = 0;
        table_drained = 1'b0;
        while (!table_drained && n_issues < ISSUE_CAP && sent + n_issues < n_beats) begin
          send_issue();
          n_issues++;
        end
        repeat ($urandom_range(2)) begin
          send_issue();
          n_issues++;
        end
        sent += n_issues;
      end
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps issuing
  task automatic squeeze();
    hold_off_req = 1'b1;
    send_beat(beat(rrss_pkg::OP_CLEAR, '0), CHK_MODEL, NO_BEAT);
    repeat (4) send_beat(beat(rrss_pkg::OP_LOAD, 16'd500), CHK_MODEL, NO_BEAT);
    repeat (40) send_issue();
  endtask

  // ---------------------------------------------------------------- output side

  // receiver stall, with an occasional long hold-off counted here
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare each taken result beat with the oldest expectation;
  // fields are shown as index/slice/round/done/full
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result beat, expected none got %0d/%0d/%0d/%0b/%0b",
                 $time, out_data.task_index, out_data.slice_length, out_data.round_number,
                 out_data.all_done, out_data.table_full);
        mismatch_cnt++;
      end else begin
        head_grant = pending_grants.pop_front();
        if (out_data.task_index   !== head_grant.task_index   ||
            out_data.slice_length !== head_grant.slice_length ||
            out_data.round_number !== head_grant.round_number ||
            out_data.all_done     !== head_grant.all_done     ||
            out_data.table_full   !== head_grant.table_full) begin
          $display("%0t: mismatch, expected %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                   $time, head_grant.task_index, head_grant.slice_length,
                   head_grant.round_number, head_grant.all_done, head_grant.table_full,
                   out_data.task_index, out_data.slice_length, out_data.round_number,
                   out_data.all_done, out_data.table_full);
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    loaded_cnt  = 0;
    next_slot   = 0;
    round_no    = rrss_pkg::ROUND_FIRST;
    quantum_q   = rrss_pkg::QUANTUM_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed plan
    foreach (plan[i])
      repeat (plan[i].reps)
        send_beat(beat(plan[i].op, plan[i].burst), plan[i].chk, plan[i].want);

    // random phases, each with its own quantum and idling
    for (int unsigned p = 0; p < N_PHASES; p++) begin
      write_quantum(PHASE_QUANTUM[p]);
      set_idling(p % 4);
      random_traffic(PHASE_BEATS / 2);
      if (p == 2) squeeze();
      quiesce();
      random_traffic(PHASE_BEATS / 2);
    end

    // zero quantum: slices of length 0 are granted and the task never advances
    write_quantum('0);
    set_idling(0);
    send_beat(beat(rrss_pkg::OP_CLEAR, '0), CHK_MODEL, NO_BEAT);
    send_beat(beat(rrss_pkg::OP_LOAD, 16'hFFFF), CHK_MODEL, NO_BEAT);
    repeat (ZERO_Q_ISSUES) send_issue();

    quiesce();
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
